/* src/bov_pkg.sv */
// Package for the block orientation vote unit: register codes, reset values,
// widths and the structs passed between the raster, accumulator and pick stages.
// No dependencies.
package bov_pkg;

  // Grid and field sizes.
  localparam int unsigned BinCount       = 8;
  localparam int unsigned BinW           = 3;
  localparam int unsigned MaxTileSide    = 64;
  localparam int unsigned MaxTilesAcross = 64;
  localparam int unsigned MaxTilesDown   = 64;
  localparam int unsigned MaxImageSide   = 4096;
  localparam int unsigned ColW           = 6;
  localparam int unsigned RowW           = 6;
  localparam int unsigned TileIdxW       = 7;
  localparam int unsigned OffsetW        = 6;
  localparam int unsigned PosW           = 12;
  localparam int unsigned SizeW          = 13;
  localparam int unsigned SmallW         = 7;
  localparam int unsigned VoteW          = 14;
  localparam int unsigned MagW           = 8;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 13;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_TILE_SIDE    = 3'd2,
    CFG_TILES_ACROSS = 3'd3,
    CFG_TILES_DOWN   = 3'd4
  } cfg_reg_e;

  // Register values after reset.
  localparam logic [SizeW-1:0]  ResetImageWidth  = 13'd640;
  localparam logic [SizeW-1:0]  ResetImageHeight = 13'd480;
  localparam logic [SmallW-1:0] ResetTileSide    = 7'd16;
  localparam logic [SmallW-1:0] ResetTilesAcross = 7'd40;
  localparam logic [SmallW-1:0] ResetTilesDown   = 7'd30;

  // One pixel command from the raster tracker to the accumulator.
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic [ColW-1:0]   col;
    logic [RowW-1:0]   row;
    logic [BinW-1:0]   bin;
    logic [MagW-1:0]   mag;
  } pix_cmd_t;

  // One accumulator entry: eight vote counts and eight peaks.
  typedef struct packed {
    logic [BinCount-1:0][VoteW-1:0] votes;
    logic [BinCount-1:0][MagW-1:0]  peaks;
  } acc_entry_t;

  // A finished tile handed to the pick stage.
  typedef struct packed {
    logic            valid;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    acc_entry_t      acc;
  } tile_res_t;

endpackage

/* src/block_orientation_vote_unit.sv */
// Top level of the block orientation vote unit.
// Depends on bov_pkg, bov_raster, bov_accum and bov_vote_pick.
//
//   Channel  Direction  Handshake               Payload
//   cfg      in         cfg_we_i                cfg_index_i, cfg_data_i
//   in       in         in_valid_i / in_stall_o direction_code_i, magnitude_i
//   out      out        out_valid_o/out_stall_i tile_column_o .. peak_strength_o
//
// One pixel item is taken every cycle while in_stall_o is low; the accumulator
// memory read, the read-modify-write in stage one and the forwarded last
// write set that rate. After its last pixel, a tile result passes stage one,
// stage two and the output register. Reset clears the position, the entry valid
// bits and the pipeline at once; there is no clearing pass over the memory.
// in_stall_o rises only while a finished tile waits behind a stalled output.
module block_orientation_vote_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bov_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bov_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    direction_code_i,
  input  logic [bov_pkg::MagW-1:0]      magnitude_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bov_pkg::ColW-1:0]      tile_column_o,
  output logic [bov_pkg::RowW-1:0]      tile_row_o,
  output logic [bov_pkg::BinW-1:0]      best_bin_o,
  output logic [7:0]                    vote_total_o,
  output logic [bov_pkg::MagW-1:0]      peak_strength_o
);

  bov_pkg::pix_cmd_t  cmd;
  bov_pkg::tile_res_t res;
  logic               restart, stall, accept;

  assign accept     = in_valid_i && !stall;
  assign in_stall_o = stall;

  bov_raster u_raster (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .accept_i   (accept),
    .direction_code_i,
    .magnitude_i,
    .cmd_o      (cmd),
    .restart_o  (restart)
  );

  bov_accum u_accum (
    .clk_i,
    .rst_ni,
    .restart_i (restart),
    .adv_i     (!stall),
    .cmd_i     (cmd),
    .res_o     (res)
  );

  bov_vote_pick u_pick (
    .clk_i,
    .rst_ni,
    .res_i      (res),
    .out_stall_i,
    .stall_o    (stall),
    .out_valid_o,
    .tile_column_o,
    .tile_row_o,
    .best_bin_o,
    .vote_total_o,
    .peak_strength_o
  );

endmodule

/* src/bov_raster.sv */
// Raster position tracker and configuration registers for the vote unit.
// Depends on bov_pkg; gives one pixel command per accepted in-grid item.
module bov_raster (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bov_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bov_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          accept_i,
  input  logic [7:0]                    direction_code_i,
  input  logic [bov_pkg::MagW-1:0]      magnitude_i,
  output bov_pkg::pix_cmd_t             cmd_o,
  output logic                          restart_o
);

  logic [bov_pkg::SizeW-1:0]    width_q, height_q;
  logic [bov_pkg::SmallW-1:0]   side_q, across_q, down_q;
  logic [bov_pkg::PosW-1:0]     px_q, px_d, py_q, py_d;
  logic [bov_pkg::OffsetW-1:0]  ox_q, ox_d, oy_q, oy_d;
  logic [bov_pkg::TileIdxW-1:0] tx_q, tx_d, ty_q, ty_d;
  logic [bov_pkg::SmallW-1:0]   ox_inc, oy_inc;
  logic                         last_col, last_row, in_grid, end_x, end_y;

  // Clamp a wide size register into 1..MaxImageSide.
  function automatic logic [bov_pkg::SizeW-1:0] clamp_size(
    input logic [bov_pkg::SizeW-1:0] v
  );
    logic [bov_pkg::SizeW-1:0] r;
    r = v;
    if (v == '0) r = bov_pkg::SizeW'(1);
    else if (v > bov_pkg::SizeW'(bov_pkg::MaxImageSide)) r = bov_pkg::SizeW'(bov_pkg::MaxImageSide);
    return r;
  endfunction

  // Clamp a tile-count or tile-side register into 1..64.
  function automatic logic [bov_pkg::SmallW-1:0] clamp_small(
    input logic [bov_pkg::SmallW-1:0] v
  );
    logic [bov_pkg::SmallW-1:0] r;
    r = v;
    if (v == '0) r = bov_pkg::SmallW'(1);
    else if (v > bov_pkg::SmallW'(bov_pkg::MaxTileSide)) r = bov_pkg::SmallW'(bov_pkg::MaxTileSide);
    return r;
  endfunction

  // Any write to a known register restarts the frame.
  always_comb begin
    restart_o = 1'b0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bov_pkg::CFG_IMAGE_WIDTH,
        bov_pkg::CFG_IMAGE_HEIGHT,
        bov_pkg::CFG_TILE_SIDE,
        bov_pkg::CFG_TILES_ACROSS,
        bov_pkg::CFG_TILES_DOWN: restart_o = 1'b1;
        default:                 restart_o = 1'b0;
      endcase
    end
  end

  // Configuration registers hold the clamped values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bov_pkg::ResetImageWidth;
      height_q <= bov_pkg::ResetImageHeight;
      side_q   <= bov_pkg::ResetTileSide;
      across_q <= bov_pkg::ResetTilesAcross;
      down_q   <= bov_pkg::ResetTilesDown;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bov_pkg::CFG_IMAGE_WIDTH:  width_q  <= clamp_size(cfg_data_i);
        bov_pkg::CFG_IMAGE_HEIGHT: height_q <= clamp_size(cfg_data_i);
        bov_pkg::CFG_TILE_SIDE:    side_q   <= clamp_small(cfg_data_i[bov_pkg::SmallW-1:0]);
        bov_pkg::CFG_TILES_ACROSS: across_q <= clamp_small(cfg_data_i[bov_pkg::SmallW-1:0]);
        bov_pkg::CFG_TILES_DOWN:   down_q   <= clamp_small(cfg_data_i[bov_pkg::SmallW-1:0]);
        default: ;
      endcase
    end
  end

  // Edge and tile-end flags for the current pixel.
  always_comb begin
    last_col = ({1'b0, px_q} + bov_pkg::SizeW'(1)) >= width_q;
    last_row = ({1'b0, py_q} + bov_pkg::SizeW'(1)) >= height_q;
    in_grid  = (tx_q < across_q) && (ty_q < down_q);
    ox_inc   = {1'b0, ox_q} + bov_pkg::SmallW'(1);
    oy_inc   = {1'b0, oy_q} + bov_pkg::SmallW'(1);
    end_x    = (ox_inc == side_q) || last_col;
    end_y    = (oy_inc == side_q) || last_row;
  end

  // Command for the accumulator, built from the position before the update.
  always_comb begin
    cmd_o.valid = accept_i && in_grid;
    cmd_o.emit  = end_x && end_y;
    cmd_o.col   = tx_q[bov_pkg::ColW-1:0];
    cmd_o.row   = ty_q[bov_pkg::RowW-1:0];
    cmd_o.bin   = direction_code_i[bov_pkg::BinW-1:0];
    cmd_o.mag   = magnitude_i;
  end

  // Next raster position; tile indices stop at the grid size.
  always_comb begin
    px_d = px_q;
    py_d = py_q;
    ox_d = ox_q;
    oy_d = oy_q;
    tx_d = tx_q;
    ty_d = ty_q;
    if (last_col) begin
      px_d = '0;
      ox_d = '0;
      tx_d = '0;
      if (last_row) begin
        py_d = '0;
        oy_d = '0;
        ty_d = '0;
      end else begin
        py_d = py_q + bov_pkg::PosW'(1);
        if (oy_inc >= side_q) begin
          oy_d = '0;
          if (ty_q < down_q) ty_d = ty_q + bov_pkg::TileIdxW'(1);
        end else begin
          oy_d = oy_inc[bov_pkg::OffsetW-1:0];
        end
      end
    end else begin
      px_d = px_q + bov_pkg::PosW'(1);
      if (ox_inc >= side_q) begin
        ox_d = '0;
        if (tx_q < across_q) tx_d = tx_q + bov_pkg::TileIdxW'(1);
      end else begin
        ox_d = ox_inc[bov_pkg::OffsetW-1:0];
      end
    end
  end

  // Position registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0;
      py_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
      tx_q <= '0;
      ty_q <= '0;
    end else if (restart_o) begin
      px_q <= '0;
      py_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
      tx_q <= '0;
      ty_q <= '0;
    end else if (accept_i) begin
      px_q <= px_d;
      py_q <= py_d;
      ox_q <= ox_d;
      oy_q <= oy_d;
      tx_q <= tx_d;
      ty_q <= ty_d;
    end
  end

endmodule

/* src/bov_accum.sv */
// Per-column accumulator memory with read-modify-write and write forwarding.
// Depends on bov_pkg; takes pixel commands, hands finished tiles onwards.
module bov_accum (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               restart_i,
  input  logic               adv_i,
  input  bov_pkg::pix_cmd_t  cmd_i,
  output bov_pkg::tile_res_t res_o
);

  localparam int unsigned Depth = bov_pkg::MaxTilesAcross;

  bov_pkg::acc_entry_t mem [Depth];
  bov_pkg::acc_entry_t ram_q, fwd_q, old_ent, new_ent, wr_data;
  bov_pkg::pix_cmd_t   s1_q;
  logic [Depth-1:0]    ent_valid_q;
  logic                fwd_valid_q;
  logic [bov_pkg::ColW-1:0] fwd_addr_q;
  logic                wr_en;
  logic [bov_pkg::BinW-1:0] bin_up, bin_dn;

  // Stage one register: the command whose entry is being read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv_i) begin
      s1_q <= cmd_i;
    end
  end

  // Memory: registered read at accept, write back from stage one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && adv_i) ram_q <= mem[cmd_i.col];
    if (wr_en) mem[s1_q.col] <= wr_data;
  end

  // Entry valid bits; an entry never written reads as all zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
    end else if (restart_i) begin
      ent_valid_q <= '0;
    end else if (wr_en) begin
      ent_valid_q[s1_q.col] <= 1'b1;
    end
  end

  // The last write is kept to cover a read issued at the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      fwd_addr_q  <= '0;
    end else if (restart_i) begin
      fwd_valid_q <= 1'b0;
    end else if (wr_en) begin
      fwd_valid_q <= 1'b1;
      fwd_addr_q  <= s1_q.col;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) fwd_q <= wr_data;
  end

  // Select the current entry contents, then add the votes and raise the peak.
  always_comb begin
    bin_up = s1_q.bin + bov_pkg::BinW'(1);
    bin_dn = s1_q.bin - bov_pkg::BinW'(1);
    if (fwd_valid_q && (fwd_addr_q == s1_q.col)) old_ent = fwd_q;
    else if (ent_valid_q[s1_q.col])                old_ent = ram_q;
    else                                            old_ent = '0;
    new_ent = old_ent;
    for (int b = 0; b < bov_pkg::BinCount; b++) begin
      if (bov_pkg::BinW'(b) == s1_q.bin) begin
        new_ent.votes[b] = old_ent.votes[b] + bov_pkg::VoteW'(2);
      end else if ((bov_pkg::BinW'(b) == bin_up) || (bov_pkg::BinW'(b) == bin_dn)) begin
        new_ent.votes[b] = old_ent.votes[b] + bov_pkg::VoteW'(1);
      end
    end
    if (old_ent.peaks[s1_q.bin] < s1_q.mag) new_ent.peaks[s1_q.bin] = s1_q.mag;
    wr_en   = s1_q.valid && adv_i;
    wr_data = s1_q.emit ? '0 : new_ent;
  end

  // A finishing tile leaves its totals and clears its entry.
  always_comb begin
    res_o.valid = wr_en && s1_q.emit;
    res_o.col   = s1_q.col;
    res_o.row   = s1_q.row;
    res_o.acc   = new_ent;
  end

endmodule

/* src/bov_vote_pick.sv */
// Best-bin selection and the output register of the vote unit.
// Depends on bov_pkg; takes finished tiles from the accumulator.
module bov_vote_pick (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bov_pkg::tile_res_t        res_i,
  input  logic                      out_stall_i,
  output logic                      stall_o,
  output logic                      out_valid_o,
  output logic [bov_pkg::ColW-1:0]  tile_column_o,
  output logic [bov_pkg::RowW-1:0]  tile_row_o,
  output logic [bov_pkg::BinW-1:0]  best_bin_o,
  output logic [7:0]                vote_total_o,
  output logic [bov_pkg::MagW-1:0]  peak_strength_o
);

  bov_pkg::tile_res_t       s2_q;
  logic                     s2_valid_q, out_valid_q, out_load;
  logic [bov_pkg::BinW-1:0] best;
  logic [bov_pkg::VoteW-1:0] most;
  logic [7:0]               total_sat;
  logic [bov_pkg::ColW-1:0] col_q;
  logic [bov_pkg::RowW-1:0] row_q;
  logic [bov_pkg::BinW-1:0] best_q;
  logic [7:0]               total_q;
  logic [bov_pkg::MagW-1:0] peak_q;

  // The pipeline holds only while a tile here waits behind a stalled output.
  assign stall_o  = s2_valid_q && out_valid_q && out_stall_i;
  assign out_load = !out_valid_q || !out_stall_i;

  // Stage two register for a finished tile.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!stall_o) begin
      s2_valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid && !stall_o) s2_q <= res_i;
  end

  // Highest count wins; a strict compare keeps the lowest index on ties.
  always_comb begin
    best = '0;
    most = '0;
    for (int d = 0; d < bov_pkg::BinCount; d++) begin
      if (s2_q.acc.votes[d] > most) begin
        most = s2_q.acc.votes[d];
        best = bov_pkg::BinW'(d);
      end
    end
    total_sat = (most > bov_pkg::VoteW'(255)) ? 8'd255 : most[7:0];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s2_valid_q) begin
      col_q   <= s2_q.col;
      row_q   <= s2_q.row;
      best_q  <= best;
      total_q <= total_sat;
      peak_q  <= s2_q.acc.peaks[best];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tile_column_o   = col_q;
  assign tile_row_o      = row_q;
  assign best_bin_o      = best_q;
  assign vote_total_o    = total_q;
  assign peak_strength_o = peak_q;

endmodule

/* src/bov_checker.sv */
// Port-level checks for the block orientation vote unit, bound to the top level.
// Depends on bov_pkg for the port widths.
module bov_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [bov_pkg::ColW-1:0]      tile_column_o,
  input logic [bov_pkg::RowW-1:0]      tile_row_o,
  input logic [bov_pkg::BinW-1:0]      best_bin_o,
  input logic [7:0]                    vote_total_o,
  input logic [bov_pkg::MagW-1:0]      peak_strength_o
);

  // A stalled result item stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(tile_column_o) && $stable(tile_row_o)
      && $stable(best_bin_o) && $stable(vote_total_o) && $stable(peak_strength_o))
    else $error("result payload changed while stalled");

  // The input side stalls only behind a full, stalled output register.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  // Every emitted tile holds at least one pixel, so its best bin has >= 2 votes.
  a_votes_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> vote_total_o >= 8'd2)
    else $error("tile result with fewer than two votes");

endmodule

bind block_orientation_vote_unit bov_checker u_bov_checker (.*);

/* bench/tb.sv */
// Self-checking bench for block_orientation_vote_unit: pixel items are streamed in raster
// order under several tilings and every finished tile is checked against a predicted one.
// Depends on bov_pkg and the block_orientation_vote_unit RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bov_pkg::*;

  localparam int unsigned VoteCeiling  = 255;
  localparam int unsigned BurstMax     = 12;
  localparam int unsigned RandomItems  = 600;
  localparam int unsigned CalmFrom     = 450;
  localparam int unsigned PhaseCap     = 200;
  localparam int unsigned SettleCycles = 8;

  // One finished tile as it leaves the block.
  typedef struct packed {
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic [BinW-1:0] bin;
    logic [7:0]      votes;
    logic [MagW-1:0] peak;
  } tile_result_t;

  // Tracks the raster position and per-column accumulators, and holds the tiles due.
  class tile_vote_predictor;
    int unsigned  reg_w, reg_h, reg_side, reg_across, reg_down;
    int unsigned  px, py, ox, oy, tx, ty;
    int unsigned  votes [MaxTilesAcross][BinCount];
    int unsigned  peaks [MaxTilesAcross][BinCount];
    tile_result_t tiles_due [$];
    int           errors;

    function new();
      reg_w      = ResetImageWidth;
      reg_h      = ResetImageHeight;
      reg_side   = ResetTileSide;
      reg_across = ResetTilesAcross;
      reg_down   = ResetTilesDown;
      errors     = 0;
      restart();
    endfunction

    // Back to the first pixel of a fresh frame with empty accumulators.
    function void restart();
      px = 0; py = 0; ox = 0; oy = 0; tx = 0; ty = 0;
      foreach (votes[i, j]) begin
        votes[i][j] = 0;
        peaks[i][j] = 0;
      end
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned frame_pixels();
      return clamp(reg_w, 1, MaxImageSide) * clamp(reg_h, 1, MaxImageSide);
    endfunction

    // Any write to a real register restarts the frame; unused indexes are ignored.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_IMAGE_WIDTH:  reg_w = val;
        CFG_IMAGE_HEIGHT: reg_h = val;
        CFG_TILE_SIDE:    reg_side = val[SmallW-1:0];
        CFG_TILES_ACROSS: reg_across = val[SmallW-1:0];
        CFG_TILES_DOWN:   reg_down = val[SmallW-1:0];
        default:          return;
      endcase
      restart();
    endfunction

    // Adds one accepted pixel and queues a tile when it was the tile's last.
    function void note_pixel(logic [7:0] code, logic [MagW-1:0] mag);
      int unsigned  w, h, ts, ta, td, most;
      logic [BinW-1:0] bin, best;
      bit           last_col, last_row;
      tile_result_t res;
      w  = clamp(reg_w, 1, MaxImageSide);
      h  = clamp(reg_h, 1, MaxImageSide);
      ts = clamp(reg_side, 1, MaxTileSide);
      ta = clamp(reg_across, 1, MaxTilesAcross);
      td = clamp(reg_down, 1, MaxTilesDown);
      bin = code[BinW-1:0];
      last_col = (px + 1 >= w);
      last_row = (py + 1 >= h);

      if (tx < ta && ty < td) begin
        votes[tx][bin] += 2;
        votes[tx][bin + 3'd1] += 1;
        votes[tx][bin - 3'd1] += 1;
        if (peaks[tx][bin] < mag) peaks[tx][bin] = mag;
        if ((ox + 1 == ts || last_col) && (oy + 1 == ts || last_row)) begin
          best = 0;
          most = 0;
          for (int d = 0; d < BinCount; d++) begin
            if (votes[tx][d] > most) begin
              most = votes[tx][d];
              best = BinW'(d);
            end
          end
          res.col   = ColW'(tx);
          res.row   = RowW'(ty);
          res.bin   = best;
          res.votes = (most > VoteCeiling) ? 8'(VoteCeiling) : 8'(most);
          res.peak  = MagW'(peaks[tx][best]);
          tiles_due.push_back(res);
          for (int d = 0; d < BinCount; d++) begin
            votes[tx][d] = 0;
            peaks[tx][d] = 0;
          end
        end
      end

      // Raster advance; tile indices stop at the grid size.
      if (last_col) begin
        px = 0; ox = 0; tx = 0;
        if (last_row) begin
          py = 0; oy = 0; ty = 0;
        end else begin
          py++;
          oy++;
          if (oy >= ts) begin
            oy = 0;
            if (ty < td) ty++;
          end
        end
      end else begin
        px++;
        ox++;
        if (ox >= ts) begin
          ox = 0;
          if (tx < ta) tx++;
        end
      end
    endfunction

    function int pending();
      return tiles_due.size();
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    // Compares one accepted tile with the oldest one due.
    task check_tile(tile_result_t got);
      tile_result_t want;
      if (tiles_due.size() == 0) begin
        report($sformatf("tile col %0d row %0d arrived with none due", got.col, got.row));
        return;
      end
      want = tiles_due.pop_front();
      if (got.col != want.col)
        report($sformatf("tile_column got %0d, want %0d", got.col, want.col));
      if (got.row != want.row)
        report($sformatf("tile_row got %0d, want %0d", got.row, want.row));
      if (got.bin != want.bin)
        report($sformatf("best_bin got %0d, want %0d (tile %0d,%0d)",
                         got.bin, want.bin, want.col, want.row));
      if (got.votes != want.votes)
        report($sformatf("vote_total got %0d, want %0d (tile %0d,%0d)",
                         got.votes, want.votes, want.col, want.row));
      if (got.peak != want.peak)
        report($sformatf("peak_strength got %0d, want %0d (tile %0d,%0d)",
                         got.peak, want.peak, want.col, want.row));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni           = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i       = '0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic [7:0]          direction_code_i = '0;
  logic [MagW-1:0]     magnitude_i      = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic [ColW-1:0]     tile_column_o;
  logic [RowW-1:0]     tile_row_o;
  logic [BinW-1:0]     best_bin_o;
  logic [7:0]          vote_total_o;
  logic [MagW-1:0]     peak_strength_o;

  tile_vote_predictor sb;
  int unsigned idle_odds  = 0;
  int unsigned stall_odds = 0;
  int unsigned stall_left = 0;
  bit          bias_on    = 1'b0;
  logic [BinW-1:0] bias_bin = '0;

  // Hand-picked pixels for the first, cut tiling: every bin, high code bits, magnitude extremes.
  logic [7:0]      demo_codes [15] = '{8'd0, 8'd7, 8'd255, 8'd8, 8'd4, 8'd1, 8'd3, 8'd2,
                                       8'd6, 8'd5, 8'd248, 8'd15, 8'd0, 8'd128, 8'd71};
  logic [MagW-1:0] demo_mags  [15] = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd0, 8'd17,
                                       8'd255, 8'd200, 8'd99, 8'd255, 8'd3, 8'd255, 8'd64,
                                       8'd7};

  block_orientation_vote_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .direction_code_i (direction_code_i),
    .magnitude_i      (magnitude_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .tile_column_o    (tile_column_o),
    .tile_row_o       (tile_row_o),
    .best_bin_o       (best_bin_o),
    .vote_total_o     (vote_total_o),
    .peak_strength_o  (peak_strength_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Output stalls come in bursts whose frequency is set per phase.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(1, BurstMax);
    end
    out_stall_i <= (stall_left > 0);
  end

  // Every accepted tile goes to the checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_tile({tile_column_o, tile_row_o, best_bin_o, vote_total_o, peak_strength_o});
  end

  function automatic logic [7:0] random_code();
    if (bias_on && $urandom_range(0, 3) != 0) return {5'($urandom), bias_bin};
    return 8'($urandom);
  endfunction

  function automatic logic [MagW-1:0] random_mag();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return MagW'($urandom);
    endcase
  endfunction

  // Mostly small sizes, now and then zero or any 13-bit value to hit the clamps.
  function automatic logic [CfgDataW-1:0] random_size(int unsigned top);
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return CfgDataW'($urandom);
      default: return CfgDataW'($urandom_range(1, top));
    endcase
  endfunction

  task automatic pick_idling();
    case ($urandom_range(0, 2))
      0:       idle_odds = 0;
      1:       idle_odds = 4;
      default: idle_odds = 16;
    endcase
    case ($urandom_range(0, 2))
      0:       stall_odds = 0;
      1:       stall_odds = 4;
      default: stall_odds = 16;
    endcase
  endtask

  // Sends one pixel item, with an occasional idle burst ahead of it.
  task automatic send_pixel(logic [7:0] code, logic [MagW-1:0] mag);
    int unsigned gap;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, BurstMax);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    direction_code_i <= code;
    magnitude_i      <= mag;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pixel(code, mag);
  endtask

  // Lets every due tile come out, then lets the block settle for pixels that emit nothing.
  task automatic wait_for_tiles();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write enable stays high across back-to-back writes and is lowered by end_writes.
  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
  endtask

  task automatic program_tiling(logic [CfgDataW-1:0] w, logic [CfgDataW-1:0] h,
                                logic [CfgDataW-1:0] ts, logic [CfgDataW-1:0] ta,
                                logic [CfgDataW-1:0] td);
    write_register(CFG_IMAGE_WIDTH, w);
    write_register(CFG_IMAGE_HEIGHT, h);
    write_register(CFG_TILE_SIDE, ts);
    write_register(CFG_TILES_ACROSS, ta);
    write_register(CFG_TILES_DOWN, td);
    end_writes();
  endtask

  task automatic send_random_pixels(int unsigned n);
    repeat (n) send_pixel(random_code(), random_mag());
  endtask

  // Main sequence.
  initial begin
    int unsigned random_count;
    int unsigned frame;
    int unsigned n;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset width, tile side and grid with a one-row image: one full row of cut tiles.
    pick_idling();
    write_register(CFG_IMAGE_HEIGHT, 13'd1);
    end_writes();
    send_random_pixels(640);
    wait_for_tiles();

    // Cut right and bottom tiles, then every register at zero so each pixel is a tile.
    program_tiling(13'd5, 13'd3, 13'd2, 13'd3, 13'd2);
    for (int i = 0; i < 15; i++) send_pixel(demo_codes[i], demo_mags[i]);
    wait_for_tiles();
    program_tiling('0, '0, '0, '0, '0);
    send_random_pixels(10);
    wait_for_tiles();

    // Clamped width and tile side, with pixels beyond the last tile column.
    pick_idling();
    program_tiling('1, 13'd1, '1, 13'd2, 13'h7F);
    send_random_pixels(160);
    wait_for_tiles();

    // Clamped height, one pixel wide, with rows below the last tile row.
    program_tiling(13'd1, 13'h1FFF, 13'd64, 13'h7F, 13'd2);
    send_random_pixels(140);
    wait_for_tiles();

    // One direction dominates a large tile so the vote count saturates.
    bias_on  = 1'b1;
    bias_bin = BinW'($urandom);
    program_tiling(13'd16, 13'd16, 13'd16, 13'd1, 13'd1);
    send_random_pixels(256);
    wait_for_tiles();

    // Random tilings; the last stretch runs without idling on either side.
    random_count = 0;
    while (random_count < RandomItems) begin
      if (random_count >= CalmFrom) begin
        idle_odds  = 0;
        stall_odds = 0;
      end else begin
        pick_idling();
      end
      bias_on  = ($urandom_range(0, 3) == 0);
      bias_bin = BinW'($urandom);
      case ($urandom_range(0, 5))
        0: begin
          // An unused index must leave the frame running.
          write_register(CfgIdxW'(CFG_TILES_DOWN) + CfgIdxW'($urandom_range(1, 3)),
                         CfgDataW'($urandom));
          end_writes();
        end
        1: begin
          write_register(CfgIdxW'($urandom_range(CFG_IMAGE_WIDTH, CFG_TILES_DOWN)),
                         random_size(12));
          end_writes();
        end
        default: begin
          program_tiling(random_size(16), random_size(16), random_size(8),
                         random_size(8), random_size(8));
        end
      endcase
      frame = sb.frame_pixels();
      n = frame * $urandom_range(1, 3) + $urandom_range(0, frame - 1);
      if (n > PhaseCap) n = PhaseCap;
      send_random_pixels(n);
      random_count += n;
      wait_for_tiles();
    end

    repeat (2 * SettleCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
